/* src/sliding_window_median_core_defines.svh */
// Assertion macros for the sliding window median core.
// Used by the RTL file that carries concurrent checks; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_CORE_DEFINES_SVH

// Check sampled on the rising clock, switched off while reset is held
`define SWM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check sampled on the rising clock, live during reset as well
`define SWM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* src/swm_pkg.sv */
// Shared types and constants for the sliding window median core.
// No dependencies; imported by every module of the block.
`default_nettype none

package swm_pkg;

    localparam int DEF_MAX_WINDOW = 64;
    localparam int SAMPLE_W       = 32;
    localparam int CFG_W          = 7;
    localparam int OUT_W          = 33;
    localparam int OUT_TDATA_W    = 40;

    // One cell's view as seen by a neighbour
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       le;     // value <= incoming sample (and valid)
    } t_link;

    // Per-cell control for one update of the sorted chain
    typedef struct packed {
        logic step;     // a request is taken this cycle, with no length write
        logic shift;    // the removed cell lies at or below this one
        logic valid_c;  // this slot is occupied once the oldest is removed
    } t_step_ctl;

endpackage

`default_nettype wire

/* src/sliding_window_median_core.sv */
// Sliding window median: a sorted chain of cells, one sample per cell.
// One sample per cycle unless a pending result waits on a stalled receiver;
// each request updates the whole chain at once; r_pend rises before o_m_tvalid.
// Reset (sync, active low) empties the window and sets the length to one.
// A length write also empties the window; results wait until it refills.
// Depends on swm_pkg, swm_cell, swm_out and the defines header.
`default_nettype none
`include "sliding_window_median_core_defines.svh"

module sliding_window_median_core
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_W-1:0]       i_cfg_wdata,  // window_length
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [SAMPLE_W-1:0]    i_s_tdata,    // [31:0] sample
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata     // [32:0] median_doubled
);

    localparam int LEN_W = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [LEN_W-1:0] r_len, r_fill, n_fill;
    logic [IDX_W-1:0] r_idx_lo, r_idx_hi;
    logic             r_pend, n_pend;

    logic             w_free, w_move, w_acc, w_full;
    logic [LEN_W-1:0] w_m, w_len_m1;
    logic [31:0]      w_cfg_len;
    logic signed [SAMPLE_W-1:0] w_sample;
    logic [MAX_WINDOW-1:0] w_rm;

    t_link            w_raw     [MAX_WINDOW];
    t_link            w_cmp     [MAX_WINDOW];
    logic [IDX_W-1:0] w_age     [MAX_WINDOW];
    logic [IDX_W-1:0] w_cmp_age [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] w_vals [MAX_WINDOW];

    // handshake: a pending result must be able to move on
    assign w_move     = r_pend && w_free;
    assign o_s_tready = !r_pend || w_free;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_sample   = i_s_tdata;

    // window occupancy after removing the oldest sample
    assign w_full   = (r_fill == r_len);
    assign w_len_m1 = r_len - LEN_W'(1);
    assign w_m      = w_full ? w_len_m1 : r_fill;
    assign n_fill   = w_m + LEN_W'(1);

    // clamp the written length to 1 .. MAX_WINDOW
    always_comb begin
        if (i_cfg_wdata == '0) begin
            w_cfg_len = 32'd1;
        end else if (32'(i_cfg_wdata) > 32'(MAX_WINDOW)) begin
            w_cfg_len = 32'(MAX_WINDOW);
        end else begin
            w_cfg_len = 32'(i_cfg_wdata);
        end
    end

    // result pending flag
    always_comb begin
        n_pend = r_pend;
        if (w_acc) begin
            n_pend = (n_fill == r_len);
        end else if (w_move) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= LEN_W'(1);
            r_fill   <= '0;
            r_idx_lo <= '0;
            r_idx_hi <= '0;
            r_pend   <= 1'b0;
        end else if (i_cfg_we) begin
            r_len    <= w_cfg_len[LEN_W-1:0];
            r_fill   <= '0;
            r_idx_lo <= IDX_W'((w_cfg_len - 32'd1) >> 1);
            r_idx_hi <= IDX_W'(w_cfg_len >> 1);
            r_pend   <= 1'b0;
        end else begin
            if (w_acc) begin
                r_fill <= n_fill;
            end
            r_pend <= n_pend;
        end
    end

    // chain of sorted cells
    genvar gi;
    generate
        for (gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
            t_step_ctl        w_ctl;
            t_link            w_next;
            logic [IDX_W-1:0] w_next_age;
            t_link            w_prev;
            logic [IDX_W-1:0] w_prev_age;

            // oldest cell is removed only once the window is full
            assign w_rm[gi] = w_full && (LEN_W'(gi) < r_len)
                              && (w_age[gi] == IDX_W'(w_len_m1));

            assign w_ctl.step    = w_acc && !i_cfg_we;
            assign w_ctl.shift   = |w_rm[gi:0];
            assign w_ctl.valid_c = (LEN_W'(gi) < w_m);

            if (gi == MAX_WINDOW - 1) begin : g_top
                assign w_next     = '0;
                assign w_next_age = '0;
            end else begin : g_mid
                assign w_next     = w_raw[gi+1];
                assign w_next_age = w_age[gi+1];
            end

            if (gi == 0) begin : g_bot
                assign w_prev     = '0;
                assign w_prev_age = '0;
            end else begin : g_up
                assign w_prev     = w_cmp[gi-1];
                assign w_prev_age = w_cmp_age[gi-1];
            end

            swm_cell #(
                .IDX_W (IDX_W),
                .FIRST (gi == 0)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_sample   (w_sample),
                .i_next     (w_next),
                .i_next_age (w_next_age),
                .i_prev     (w_prev),
                .i_prev_age (w_prev_age),
                .o_raw      (w_raw[gi]),
                .o_age      (w_age[gi]),
                .o_cmp      (w_cmp[gi]),
                .o_cmp_age  (w_cmp_age[gi])
            );

            assign w_vals[gi] = w_raw[gi].value;
        end
    endgenerate

    // median pick and result register
    swm_out #(
        .MAX_WINDOW (MAX_WINDOW),
        .IDX_W      (IDX_W)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vals     (w_vals),
        .i_idx_lo   (r_idx_lo),
        .i_idx_hi   (r_idx_hi),
        .i_load     (w_move),
        .i_m_tready (i_m_tready),
        .o_free     (w_free),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

    // checks
    `SWM_ASSERT(a_fill_in_range, r_fill <= r_len, "fill count above window length")
    `SWM_ASSERT(a_pend_full, r_pend |-> (r_fill == r_len), "result pending with window not full")
    `SWM_ASSERT(a_full_pends, (w_acc && !i_cfg_we && n_fill == r_len) |=> r_pend, "completed window raised no result")
    `SWM_ASSERT(a_one_removed, $countones(w_rm) == (w_full ? 1 : 0), "removal not unique in a full window")

endmodule

`default_nettype wire

/* src/swm_cell.sv */
// One cell of the sorted sample chain: holds a sample and its age.
// Depends on swm_pkg; instantiated in a row by sliding_window_median_core.
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter bit FIRST = 1'b0
) (
    input  wire logic                       i_clk,
    input  wire t_step_ctl                  i_ctl,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire t_link                      i_next,      // raw state of the cell above
    input  wire logic [IDX_W-1:0]           i_next_age,
    input  wire t_link                      i_prev,      // compacted state of the cell below
    input  wire logic [IDX_W-1:0]           i_prev_age,
    output t_link                           o_raw,
    output logic [IDX_W-1:0]                o_age,
    output t_link                           o_cmp,
    output logic [IDX_W-1:0]                o_cmp_age
);

    logic signed [SAMPLE_W-1:0] r_value, n_value;
    logic [IDX_W-1:0]           r_age, n_age;

    // raw view of this cell
    assign o_raw.value = r_value;
    assign o_raw.le    = (r_value <= i_sample);
    assign o_age       = r_age;

    // view after the oldest sample has been taken out of the chain
    always_comb begin
        if (i_ctl.shift) begin
            o_cmp.value = i_next.value;
            o_cmp.le    = i_next.le & i_ctl.valid_c;
            o_cmp_age   = i_next_age;
        end else begin
            o_cmp.value = r_value;
            o_cmp.le    = o_raw.le & i_ctl.valid_c;
            o_cmp_age   = r_age;
        end
    end

    // keep, take the new sample, or take the neighbour below
    always_comb begin
        if (o_cmp.le) begin
            n_value = o_cmp.value;
            n_age   = o_cmp_age + IDX_W'(1);
        end else if (FIRST || i_prev.le) begin
            n_value = i_sample;
            n_age   = '0;
        end else begin
            n_value = i_prev.value;
            n_age   = i_prev_age + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_value <= n_value;
            r_age   <= n_age;
        end
    end

endmodule

`default_nettype wire

/* src/swm_out.sv */
// Median pick and output register: adds the two middle cells of the chain.
// Depends on swm_pkg; instantiated by sliding_window_median_core.
`default_nettype none

module swm_out
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int IDX_W      = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic signed [SAMPLE_W-1:0] i_vals [MAX_WINDOW],
    input  wire logic [IDX_W-1:0]           i_idx_lo,
    input  wire logic [IDX_W-1:0]           i_idx_hi,
    input  wire logic                       i_load,
    input  wire logic                       i_m_tready,
    output logic                            o_free,
    output logic                            o_m_tvalid,
    output logic [OUT_TDATA_W-1:0]          o_m_tdata   // [32:0] median_doubled
);

    logic                    r_valid;
    logic signed [OUT_W-1:0] r_sum, n_sum;
    logic signed [SAMPLE_W-1:0] w_lo, w_hi;

    // middle positions are fixed by the length register
    assign w_lo  = i_vals[i_idx_lo];
    assign w_hi  = i_vals[i_idx_hi];
    assign n_sum = OUT_W'(w_lo) + OUT_W'(w_hi);

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {{(OUT_TDATA_W - OUT_W){1'b0}}, r_sum};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_sum <= n_sum;
        end
    end

endmodule

`default_nettype wire

/* bench/sliding_window_median_core_test.sv */
`timescale 1ns / 1ps
// Testbench for the sliding window median core: directed and random sample requests,
// checked against a local prediction of the window median. Depends on swm_pkg and the RTL.

module sliding_window_median_core_test;
    import swm_pkg::*;

    localparam int  PAUSE_CYCLES = 8;        // settling margin after the last result
    localparam int  DRAIN_LIMIT  = 20000;
    localparam int  STALL_CYCLES = 400;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

    // DUT drive
    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]       i_cfg_wdata = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic [SAMPLE_W-1:0]    i_s_tdata   = '0;
    logic                   i_m_tready  = 1'b0;
    logic                   o_s_tready;
    logic                   o_m_tvalid;
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // Idle pacing and receiver hold-off
    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    int unsigned stall_asked  = 0;
    int unsigned stall_served = 0;
    int unsigned error_count  = 0;

    // Predicted window state
    logic signed [SAMPLE_W-1:0] window_samples [DEF_MAX_WINDOW];
    logic [CFG_W-1:0]           length_reg = 7'd1;
    int unsigned                fill_held  = 0;
    int unsigned                oldest_idx = 0;
    logic signed [OUT_W-1:0]    medians_due [$];

    sliding_window_median_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),    // [31:0] sample
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)     // [32:0] median_doubled
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Hard stop
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Mismatch reporting
    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Length in use: zero acts as one, saturates at the store depth
    function automatic int unsigned active_length();
        int unsigned len;
        len = length_reg;
        if (len == 0) len = 1;
        if (len > DEF_MAX_WINDOW) len = DEF_MAX_WINDOW;
        return len;
    endfunction

    // Sum of the two middle values (twice the middle one for odd lengths)
    function automatic logic signed [OUT_W-1:0] median_doubled_of_window(input int unsigned len);
        logic signed [SAMPLE_W-1:0] sorted [DEF_MAX_WINDOW];
        logic signed [SAMPLE_W-1:0] v;
        logic signed [OUT_W-1:0]    lo;
        logic signed [OUT_W-1:0]    hi;
        int i;
        int j;
        for (i = 0; i < int'(len); i++) begin
            v = window_samples[i];
            j = i;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
        end
        lo = sorted[(len - 1) / 2];
        hi = sorted[len / 2];
        return lo + hi;
    endfunction

    // Update the predicted window with one accepted sample
    task automatic advance_window(input logic signed [SAMPLE_W-1:0] s);
        int unsigned len;
        len = active_length();
        if (fill_held < len) begin
            window_samples[(oldest_idx + fill_held) % len] = s;
            fill_held++;
            if (fill_held < len) return;
        end else begin
            fill_held  = len;
            oldest_idx = oldest_idx % len;
            window_samples[oldest_idx] = s;
            oldest_idx = (oldest_idx + 1) % len;
        end
        medians_due = {medians_due, median_doubled_of_window(len)};
    endtask

    // Offer one sample request, with random idle cycles ahead of it
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= s;
        do @(posedge i_clk); while (!o_s_tready);
        advance_window(s);
    endtask

    // Stop offering, wait for all results, then let the pipeline settle
    task automatic wait_window_idle();
        int n;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        n = 0;
        while (medians_due.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge i_clk);
            n++;
        end
        repeat (PAUSE_CYCLES) @(posedge i_clk);
    endtask

    // Length write; only ever issued with the block idle
    task automatic write_length(input logic [CFG_W-1:0] len);
        wait_window_idle();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        length_reg = len;
        fill_held  = 0;
        oldest_idx = 0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return $signed(32'($urandom_range(16))) - 32'sd8;
            3:       return $urandom_range(1) ? 32'sd0 : -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly short windows, sometimes the full depth, zero or saturating codes
    function automatic logic [CFG_W-1:0] rand_length();
        case ($urandom_range(19))
            0:       return 7'd0;
            1:       return 7'd64;
            2:       return 7'($urandom_range(127, 65));
            3, 4, 5: return 7'($urandom_range(63, 9));
            default: return 7'($urandom_range(8, 1));
        endcase
    endfunction

    // Receiver: random ready, or a long hold-off when one is asked for
    initial begin
        forever begin
            @(negedge i_clk);
            if (stall_asked != stall_served) begin
                i_m_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge i_clk);
                stall_served = stall_asked;
            end else begin
                i_m_tready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        logic signed [OUT_W-1:0] exp_med;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (medians_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", o_m_tdata));
            end else begin
                exp_med = medians_due.pop_front();
                if (o_m_tdata[OUT_W-1:0] !== exp_med)
                    report_mismatch($sformatf("median_doubled got %0d expected %0d",
                                              $signed(o_m_tdata[OUT_W-1:0]), exp_med));
            end
        end
    end

    // Reset value of the length: every sample is its own median
    task automatic test_reset_length();
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(32'sd0);
        send_sample(-32'sd1);
    endtask

    // Sums at the ends of the output range
    task automatic test_extremes();
        write_length(7'd2);
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MIN);
        send_sample(S_MAX);
    endtask

    // Odd length with duplicates, and a zero length acting as one
    task automatic test_odd_and_zero();
        write_length(7'd3);
        send_sample(32'sd5);
        send_sample(-32'sd7);
        send_sample(32'sd5);
        send_sample(32'sd100);
        write_length(7'd0);
        send_sample(32'sd42);
        send_sample(S_MIN);
    endtask

    // A length write empties a partly filled window
    task automatic test_refill_after_write();
        write_length(7'd3);
        send_sample(32'sd1);
        send_sample(32'sd2);
        write_length(7'd3);
        send_sample(32'sd9);
        send_sample(-32'sd9);
        send_sample(32'sd0);
        send_sample(32'sd3);
    endtask

    // Saturating length code with the full-depth window
    task automatic test_length_limit();
        int k;
        write_length(7'd127);
        for (k = 0; k < 70; k++) send_sample(rand_sample());
        write_length(7'd64);
        for (k = 0; k < 66; k++) send_sample(rand_sample());
    endtask

    // Receiver holds off long enough for the block to stall its input
    task automatic test_output_backpressure();
        int k;
        write_length(7'd5);
        stall_asked++;
        for (k = 0; k < 60; k++) send_sample(rand_sample());
    endtask

    // Random segments of random lengths under the given idle rates
    task automatic test_random_stream(input int n_items, input int unsigned src_pct,
                                      input int unsigned snk_pct);
        int sent;
        int seg;
        int k;
        int unsigned len;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < n_items) begin
            write_length(rand_length());
            len = active_length();
            seg = len + $urandom_range(40);
            for (k = 0; k < seg; k++) send_sample(rand_sample());
            sent += seg;
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        src_idle_pct = 13;
        snk_idle_pct = 75;
        test_reset_length();
        test_extremes();
        test_odd_and_zero();
        test_refill_after_write();
        test_length_limit();
        test_output_backpressure();

        test_random_stream(260, 13, 75);
        test_random_stream(260, 75, 13);
        test_random_stream(260, 0, 0);

        wait_window_idle();
        if (medians_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", medians_due.size()));
        if (error_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
